// ===== rtl/assert_macros.svh =====
// Assertion macros used by pawukon_cal.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/pawukon_pkg.sv =====
// ----------------------------------------------------------------------------
// pawukon_pkg
// Shared widths, constants and lookup tables of the pawukon converter.
// ----------------------------------------------------------------------------
package pawukon_pkg;

	localparam int unsigned DayW     = 24;
	localparam int unsigned CycW     = 17;
	localparam int unsigned CycleDays = 210;
	localparam int unsigned EpochShift = 32;

	// Cut points of the caturwara and astawara holds.
	localparam logic [7:0] HoldFirst = 8'd70;
	localparam logic [7:0] HoldLast  = 8'd72;
	localparam logic [2:0] AstaKala  = 3'd6;
	localparam logic [1:0] CaturJaya = 2'd2;

	// Control group passed from the divider stages to the calendar stages.
	typedef struct packed {
		logic valid;
	} pipe_ctl_t;

	function automatic logic [3:0] panca_urip(input logic [2:0] p);
		unique case (p)
			3'd0:    panca_urip = 4'd9;
			3'd1:    panca_urip = 4'd7;
			3'd2:    panca_urip = 4'd4;
			3'd3:    panca_urip = 4'd8;
			default: panca_urip = 4'd5;
		endcase
	endfunction

	function automatic logic [3:0] sapta_urip(input logic [2:0] s);
		unique case (s)
			3'd0:    sapta_urip = 4'd5;
			3'd1:    sapta_urip = 4'd4;
			3'd2:    sapta_urip = 4'd3;
			3'd3:    sapta_urip = 4'd7;
			3'd4:    sapta_urip = 4'd8;
			3'd5:    sapta_urip = 4'd6;
			default: sapta_urip = 4'd9;
		endcase
	endfunction

	typedef logic [4:0] rsi_row_t [7];
	typedef rsi_row_t rsi_tab_t [30];

	localparam rsi_tab_t RsiTable = '{
		'{5'd24, 5'd8, 5'd18, 5'd8, 5'd24, 5'd24, 5'd18},
		'{5'd10, 5'd8, 5'd14, 5'd27, 5'd25, 5'd24, 5'd21},
		'{5'd14, 5'd8, 5'd14, 5'd26, 5'd20, 5'd6, 5'd3},
		'{5'd15, 5'd27, 5'd18, 5'd21, 5'd26, 5'd23, 5'd1},
		'{5'd11, 5'd6, 5'd16, 5'd24, 5'd8, 5'd18, 5'd24},
		'{5'd18, 5'd26, 5'd5, 5'd24, 5'd3, 5'd3, 5'd3},
		'{5'd13, 5'd13, 5'd5, 5'd15, 5'd13, 5'd27, 5'd27},
		'{5'd2, 5'd24, 5'd24, 5'd16, 5'd26, 5'd16, 5'd6},
		'{5'd10, 5'd26, 5'd19, 5'd26, 5'd12, 5'd16, 5'd22},
		'{5'd26, 5'd26, 5'd13, 5'd1, 5'd18, 5'd14, 5'd1},
		'{5'd16, 5'd24, 5'd13, 5'd8, 5'd17, 5'd26, 5'd19},
		'{5'd25, 5'd13, 5'd13, 5'd6, 5'd8, 5'd6, 5'd27},
		'{5'd8, 5'd6, 5'd13, 5'd8, 5'd26, 5'd3, 5'd13},
		'{5'd26, 5'd26, 5'd15, 5'd16, 5'd27, 5'd8, 5'd13},
		'{5'd21, 5'd8, 5'd6, 5'd26, 5'd26, 5'd6, 5'd14},
		'{5'd26, 5'd18, 5'd14, 5'd24, 5'd6, 5'd27, 5'd21},
		'{5'd26, 5'd26, 5'd24, 5'd8, 5'd19, 5'd19, 5'd18},
		'{5'd8, 5'd18, 5'd8, 5'd5, 5'd27, 5'd18, 5'd6},
		'{5'd10, 5'd13, 5'd13, 5'd14, 5'd26, 5'd19, 5'd19},
		'{5'd6, 5'd3, 5'd26, 5'd26, 5'd3, 5'd26, 5'd18},
		'{5'd21, 5'd15, 5'd28, 5'd24, 5'd18, 5'd9, 5'd26},
		'{5'd18, 5'd6, 5'd18, 5'd8, 5'd7, 5'd16, 5'd19},
		'{5'd26, 5'd3, 5'd8, 5'd14, 5'd26, 5'd21, 5'd8},
		'{5'd16, 5'd16, 5'd24, 5'd8, 5'd9, 5'd25, 5'd3},
		'{5'd13, 5'd10, 5'd25, 5'd25, 5'd18, 5'd25, 5'd21},
		'{5'd8, 5'd13, 5'd13, 5'd15, 5'd19, 5'd26, 5'd21},
		'{5'd5, 5'd19, 5'd5, 5'd21, 5'd27, 5'd13, 5'd24},
		'{5'd19, 5'd18, 5'd18, 5'd26, 5'd16, 5'd3, 5'd25},
		'{5'd4, 5'd3, 5'd24, 5'd26, 5'd19, 5'd26, 5'd21},
		'{5'd15, 5'd4, 5'd3, 5'd26, 5'd8, 5'd26, 5'd18}
	};

endpackage

// ===== rtl/pawukon_calendar_from_day_count.sv =====
// ----------------------------------------------------------------------------
// pawukon_calendar_from_day_count
// Day count since 1970-01-01 to Balinese pawukon calendar position.
// ----------------------------------------------------------------------------
// Input channel: in_valid / in_stall with day_number. Output channel:
// out_valid / out_stall with the calendar fields, one result per input.
// A transfer happens at a rising edge with valid high and stall low.
// The pipeline has four register stages: reciprocal multiply, quotient
// correction, residues, and table lookup into the output register.
// out_valid rises once an item has moved from valid_s1 through ctl_s2 and
// valid_s3 into the output register, and the result can then transfer.
// Throughput is one item per cycle while the receiver does not stall.
// The whole pipeline advances when the output register is empty or taken;
// when the receiver stalls with a valid result, every stage holds and
// in_stall is raised, so nothing is lost or repeated.
// Reset clears all valid bits; the data registers are not reset.
// ----------------------------------------------------------------------------
module pawukon_calendar_from_day_count (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [pawukon_pkg::DayW-1:0]  day_number,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [pawukon_pkg::CycW-1:0]  cycle_count,
	output logic [4:0]                    wuku,
	output logic                          dwiwara,
	output logic [1:0]                    triwara,
	output logic [1:0]                    caturwara,
	output logic [2:0]                    pancawara,
	output logic [2:0]                    sadwara,
	output logic [2:0]                    saptawara,
	output logic [2:0]                    astawara,
	output logic [3:0]                    sangawara,
	output logic [3:0]                    dasawara,
	output logic [4:0]                    eka_jala_rsi
);

	logic                         adv;
	pawukon_pkg::pipe_ctl_t       ctl_s2;
	logic [pawukon_pkg::CycW-1:0] cyc_s2;
	logic [7:0]                   day_s2;

	assign adv      = !(out_valid && out_stall);
	assign in_stall = !adv;

	pawukon_div u_div (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (adv),
		.in_valid   (in_valid),
		.day_number (day_number),
		.ctl_s2     (ctl_s2),
		.cyc_s2     (cyc_s2),
		.day_s2     (day_s2)
	);

	pawukon_cal u_cal (
		.clk          (clk),
		.arst_n       (arst_n),
		.adv          (adv),
		.ctl_s2       (ctl_s2),
		.cyc_s2       (cyc_s2),
		.day_s2       (day_s2),
		.valid        (out_valid),
		.cycle_count  (cycle_count),
		.wuku         (wuku),
		.dwiwara      (dwiwara),
		.triwara      (triwara),
		.caturwara    (caturwara),
		.pancawara    (pancawara),
		.sadwara      (sadwara),
		.saptawara    (saptawara),
		.astawara     (astawara),
		.sangawara    (sangawara),
		.dasawara     (dasawara),
		.eka_jala_rsi (eka_jala_rsi)
	);

endmodule

// ===== rtl/pawukon_div.sv =====
// ----------------------------------------------------------------------------
// pawukon_div
// Two-stage divide by 210: reciprocal multiply, then quotient correction.
// ----------------------------------------------------------------------------
module pawukon_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              adv,
	input  logic                              in_valid,
	input  logic [pawukon_pkg::DayW-1:0]      day_number,
	output pawukon_pkg::pipe_ctl_t            ctl_s2,
	output logic [pawukon_pkg::CycW-1:0]      cyc_s2,
	output logic [7:0]                        day_s2
);

	// floor(x * 79891 / 2^24) never exceeds x / 210 and falls short by at most one
	// for every x up to 2^24 + 31.
	localparam logic [16:0] Recip = 17'd79891;

	logic                            valid_s1;
	logic [pawukon_pkg::DayW:0]      days_s1;
	logic [pawukon_pkg::DayW+17:0]   prod_s1;
	logic [pawukon_pkg::CycW-1:0]    qe;
	logic [pawukon_pkg::DayW+8:0]    qm;
	logic [pawukon_pkg::DayW:0]      rem;
	logic [pawukon_pkg::DayW:0]      days_in;

	assign days_in = {1'b0, day_number} + (pawukon_pkg::DayW+1)'(pawukon_pkg::EpochShift);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			days_s1 <= days_in;
			prod_s1 <= days_in * Recip;
		end
	end

	assign qe  = prod_s1[pawukon_pkg::CycW+23:24];
	assign qm  = qe * 8'(pawukon_pkg::CycleDays);
	assign rem = days_s1 - qm[pawukon_pkg::DayW:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2.valid <= 1'b0;
		end else if (adv) begin
			ctl_s2.valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			if (rem >= (pawukon_pkg::DayW+1)'(pawukon_pkg::CycleDays)) begin
				cyc_s2 <= qe + 1'b1;
				day_s2 <= 8'(rem - (pawukon_pkg::DayW+1)'(pawukon_pkg::CycleDays));
			end else begin
				cyc_s2 <= qe;
				day_s2 <= rem[7:0];
			end
		end
	end

endmodule

// ===== rtl/pawukon_cal.sv =====
// ----------------------------------------------------------------------------
// pawukon_cal
// Day-of-cycle to calendar fields, in two stages: residues, then lookups.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pawukon_cal (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          adv,
	input  pawukon_pkg::pipe_ctl_t        ctl_s2,
	input  logic [pawukon_pkg::CycW-1:0]  cyc_s2,
	input  logic [7:0]                    day_s2,
	output logic                          valid,
	output logic [pawukon_pkg::CycW-1:0]  cycle_count,
	output logic [4:0]                    wuku,
	output logic                          dwiwara,
	output logic [1:0]                    triwara,
	output logic [1:0]                    caturwara,
	output logic [2:0]                    pancawara,
	output logic [2:0]                    sadwara,
	output logic [2:0]                    saptawara,
	output logic [2:0]                    astawara,
	output logic [3:0]                    sangawara,
	output logic [3:0]                    dasawara,
	output logic [4:0]                    eka_jala_rsi
);

	logic                         valid_s3;
	logic [pawukon_pkg::CycW-1:0] cyc_s3;
	logic [4:0]                   wk_s3;
	logic [2:0]                   sapta_s3, panca_s3, sad_s3, asta_s3;
	logic [1:0]                   tri_s3, catur_s3;
	logic [3:0]                   sanga_s3;

	logic [4:0]  wk_c;
	logic [7:0]  d6;
	logic [4:0]  urip;
	logic [4:0]  dasa_sum;
	logic [15:0] p7, p5, p6, p9;
	logic [5:0]  q5, q6;
	logic [6:0]  q3, q9;
	logic [7:0]  r7, r5, r6, r3, r9;

	// The operands stay below 216, where these reciprocal multiplies give exact
	// quotients; each residue is the operand less quotient times divisor.
	assign d6   = day_s2 + 8'd6;
	assign p7   = {8'd0, day_s2} * 16'd293;
	assign p5   = {8'd0, day_s2} * 16'd205;
	assign p6   = {8'd0, day_s2} * 16'd171;
	assign p9   = {8'd0, d6} * 16'd57;
	assign wk_c = p7[15:11];
	assign q5   = p5[15:10];
	assign q6   = p6[15:10];
	assign q3   = p6[15:9];
	assign q9   = p9[15:9];
	assign r7   = day_s2 - 8'(wk_c * 8'd7);
	assign r5   = day_s2 - 8'(q5 * 8'd5);
	assign r6   = day_s2 - 8'(q6 * 8'd6);
	assign r3   = day_s2 - 8'(q3 * 8'd3);
	assign r9   = d6 - 8'(q9 * 8'd9);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= ctl_s2.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cyc_s3   <= cyc_s2;
			wk_s3    <= wk_c;
			sapta_s3 <= r7[2:0];
			panca_s3 <= r5[2:0];
			sad_s3   <= r6[2:0];
			tri_s3   <= r3[1:0];
			sanga_s3 <= (day_s2 > 8'd3) ? r9[3:0] : 4'd0;
			if (day_s2 < pawukon_pkg::HoldFirst) begin
				catur_s3 <= day_s2[1:0];
				asta_s3  <= day_s2[2:0];
			end else if (day_s2 > pawukon_pkg::HoldLast) begin
				catur_s3 <= d6[1:0];
				asta_s3  <= d6[2:0];
			end else begin
				catur_s3 <= pawukon_pkg::CaturJaya;
				asta_s3  <= pawukon_pkg::AstaKala;
			end
		end
	end

	assign urip = {1'b0, pawukon_pkg::panca_urip(panca_s3)}
		+ {1'b0, pawukon_pkg::sapta_urip(sapta_s3)};
	assign dasa_sum = urip + 5'd1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid <= 1'b0;
		end else if (adv) begin
			valid <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			cycle_count  <= cyc_s3;
			wuku         <= wk_s3;
			dwiwara      <= urip[0];
			triwara      <= tri_s3;
			caturwara    <= catur_s3;
			pancawara    <= panca_s3;
			sadwara      <= sad_s3;
			saptawara    <= sapta_s3;
			astawara     <= asta_s3;
			sangawara    <= sanga_s3;
			dasawara     <= (dasa_sum >= 5'd10) ? 4'(dasa_sum - 5'd10) : dasa_sum[3:0];
			eka_jala_rsi <= pawukon_pkg::RsiTable[wk_s3][sapta_s3];
		end
	end

	`ASSERT_IMPL(a_day_range, clk, arst_n, ctl_s2.valid, day_s2 < 8'd210, "day out of cycle")
	`ASSERT_IMPL(a_wk_range, clk, arst_n, valid_s3, wk_s3 < 5'd30 && sapta_s3 < 3'd7,
		"wuku or saptawara out of range")
	`ASSERT_NEXT(a_hold, clk, arst_n, !adv, $stable(valid) && $stable(eka_jala_rsi),
		"output changed while stalled")

endmodule
